// File: rtl/min_heap_priority_queue_defines.svh
// Assertion macros shared by the heap queue RTL.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define MHPQ_ASSERT_NOW(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("heap queue check failed");
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("heap queue check failed");
`else
`define MHPQ_ASSERT_NOW(label, clk, rst_n, cond, cons)
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif

`endif

// File: rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 16;
	localparam int CNT_OUT_W = 7;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] item_key;
		logic [TAG_W-1:0] item_tag;
	} req_t;

	typedef struct packed {
		logic                 done_ok;
		logic [CNT_OUT_W-1:0] entry_count;
		logic                 top_valid;
		logic [KEY_W-1:0]     top_key;
		logic [TAG_W-1:0]     top_tag;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST_RD,
		ST_LAST_GET,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_CHK,
		ST_DN_RL,
		ST_DN_RR,
		ST_DN_CMP,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// File: rtl/mhpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Slot storage: one write port and one read port with registered read data.
module mhpq_ram #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  wire                 clk,
	input  wire                 wr_en,
	input  wire  [AW-1:0]       wr_addr,
	input  mhpq_pkg::entry_t    wr_data,
	input  wire  [AW-1:0]       rd_addr,
	output mhpq_pkg::entry_t    rd_data
);
	import mhpq_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: rtl/mhpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "min_heap_priority_queue_defines.svh"

// Sequencer for the heap: tag scan, last-entry move, sift up and sift down.
// The moving entry is held in a register and written once it settles; a single
// key comparator is shared by every compare step.
module mhpq_ctrl #(
	parameter int CAPACITY = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  mhpq_pkg::req_t      req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output mhpq_pkg::rsp_t      rsp,
	output logic [AW-1:0]       rd_addr,
	input  mhpq_pkg::entry_t    rd_data,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output mhpq_pkg::entry_t    wr_data
);
	import mhpq_pkg::*;

	localparam int IW = CW + 1;

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   scan_q, scan_d;
	logic [AW-1:0]   pos_q, pos_d;
	logic [AW-1:0]   chk_q, chk_d;
	logic            chk_v_q, chk_v_d;
	logic            first_q, first_d;
	logic            ok_q, ok_d;
	entry_t          cur_q, cur_d;
	entry_t          lft_q, lft_d;
	entry_t          top_q;
	rsp_t            rsp_q, rsp_d;
	logic            rsp_v_q, rsp_v_d;

	logic [AW-1:0]    parent_idx;
	logic [IW-1:0]    lchild_w;
	logic [IW-1:0]    rchild_w;
	logic             has_left;
	logic             has_right;
	logic [KEY_W-1:0] cmp_a;
	logic [KEY_W-1:0] cmp_b;
	logic             a_gt_b;

	assign parent_idx = (pos_q - AW'(1)) >> 1;
	assign lchild_w   = (IW'(pos_q) << 1) + IW'(1);
	assign rchild_w   = lchild_w + IW'(1);
	assign has_left   = lchild_w < IW'(cnt_q);
	assign has_right  = rchild_w < IW'(cnt_q);

	// Shared key comparator; operands depend on the step.
	always_comb begin
		unique case (state_q)
			ST_UP_CMP: begin
				cmp_a = rd_data.key;
				cmp_b = cur_q.key;
			end
			ST_DN_RR: begin
				cmp_a = lft_q.key;
				cmp_b = rd_data.key;
			end
			default: begin
				cmp_a = cur_q.key;
				cmp_b = lft_q.key;
			end
		endcase
	end

	assign a_gt_b = cmp_a > cmp_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rsp_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rsp_v_q <= rsp_v_d;
		end
	end

	always_ff @(posedge clk) begin
		scan_q  <= scan_d;
		pos_q   <= pos_d;
		chk_q   <= chk_d;
		chk_v_q <= chk_v_d;
		first_q <= first_d;
		ok_q    <= ok_d;
		cur_q   <= cur_d;
		lft_q   <= lft_d;
		rsp_q   <= rsp_d;
		if (wr_en && wr_addr == '0) begin
			top_q <= wr_data;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		scan_d  = scan_q;
		pos_d   = pos_q;
		chk_d   = chk_q;
		chk_v_d = chk_v_q;
		first_d = first_q;
		ok_d    = ok_q;
		cur_d   = cur_q;
		lft_d   = lft_q;
		rsp_d   = rsp_q;
		rsp_v_d = rsp_v_q;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;

		if (rsp_v_q && !rsp_stall) begin
			rsp_v_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cur_d.key = req.item_key;
					cur_d.tag = req.item_tag;
					if (req.func == FUNC_INSERT) begin
						if (cnt_q == CW'(CAPACITY)) begin
							ok_d    = 1'b0;
							state_d = ST_DONE;
						end else begin
							ok_d    = 1'b1;
							first_d = 1'b0;
							pos_d   = AW'(cnt_q);
							cnt_d   = cnt_q + CW'(1);
							state_d = ST_UP_RD;
						end
					end else begin
						scan_d  = '0;
						chk_v_d = 1'b0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				rd_addr = AW'(scan_q);
				if (chk_v_q && rd_data.tag == cur_q.tag) begin
					ok_d  = 1'b1;
					pos_d = chk_q;
					cnt_d = cnt_q - CW'(1);
					if (CW'(chk_q) == cnt_q - CW'(1)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_LAST_RD;
					end
				end else if (scan_q < cnt_q) begin
					chk_d   = AW'(scan_q);
					chk_v_d = 1'b1;
					scan_d  = scan_q + CW'(1);
				end else begin
					chk_v_d = 1'b0;
					if (!chk_v_q) begin
						ok_d    = 1'b0;
						state_d = ST_DONE;
					end
				end
			end
			ST_LAST_RD: begin
				rd_addr = AW'(cnt_q);
				state_d = ST_LAST_GET;
			end
			ST_LAST_GET: begin
				cur_d = rd_data;
				if (pos_q == '0) begin
					state_d = ST_DN_CHK;
				end else begin
					first_d = 1'b1;
					state_d = ST_UP_RD;
				end
			end
			ST_UP_RD: begin
				if (pos_q == '0) begin
					wr_en   = 1'b1;
					state_d = ST_DONE;
				end else begin
					rd_addr = parent_idx;
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				if (a_gt_b) begin
					// Parent moves down into the hole.
					wr_en   = 1'b1;
					wr_data = rd_data;
					pos_d   = parent_idx;
					first_d = 1'b0;
					state_d = ST_UP_RD;
				end else if (first_q) begin
					first_d = 1'b0;
					state_d = ST_DN_CHK;
				end else begin
					wr_en   = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DN_CHK: begin
				if (!has_left) begin
					wr_en   = 1'b1;
					state_d = ST_DONE;
				end else begin
					rd_addr = AW'(lchild_w);
					state_d = ST_DN_RL;
				end
			end
			ST_DN_RL: begin
				lft_d = rd_data;
				chk_d = AW'(lchild_w);
				if (has_right) begin
					rd_addr = AW'(rchild_w);
					state_d = ST_DN_RR;
				end else begin
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_RR: begin
				if (a_gt_b) begin
					lft_d = rd_data;
					chk_d = AW'(rchild_w);
				end
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				wr_en = 1'b1;
				if (a_gt_b) begin
					// Smaller child moves up into the hole.
					wr_data = lft_q;
					pos_d   = chk_q;
					state_d = ST_DN_CHK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_v_q || !rsp_stall) begin
					rsp_d.done_ok     = ok_q;
					rsp_d.entry_count = CNT_OUT_W'(cnt_q);
					rsp_d.top_valid   = cnt_q != '0;
					rsp_d.top_key     = (cnt_q != '0) ? top_q.key : '0;
					rsp_d.top_tag     = (cnt_q != '0) ? top_q.tag : '0;
					rsp_v_d           = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	`MHPQ_ASSERT_NOW(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY))
	`MHPQ_ASSERT_NOW(a_idle_no_wr, clk, arst_n, state_q == ST_IDLE, !wr_en)
	`MHPQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, state_q == ST_IDLE && req_valid, state_q != ST_IDLE)
	`MHPQ_ASSERT_NEXT(a_done_rsp, clk, arst_n, state_q == ST_DONE && (!rsp_v_q || !rsp_stall), rsp_v_q && state_q == ST_IDLE)

endmodule

`default_nettype wire

// File: rtl/min_heap_priority_queue.sv
// Binary min-heap priority queue of (key, tag) entries with remove by tag.
// Request channel: req_valid / req_stall carry req (func, item_key, item_tag).
// An insert places the entry and sifts it up; a remove finds the first slot
// holding the tag, moves the last entry there and sifts it up or down.
// Response channel: rsp_valid / rsp_stall carry rsp, one transfer per request:
// success flag, entry count after the operation and the current minimum.
// One request is in work at a time; req_stall is high until its response is
// loaded into the output register, and the next request can follow as soon
// as req_stall drops. An insert sifts up level by level until it stops or
// reaches the root; a refused insert goes straight to the response. A remove
// scans one slot a cycle through the single registered read port of the slot
// RAM, which sets this pace; a miss or a hit in the last slot then answers
// directly, and any other hit moves the last entry into the found slot and
// sifts it up or down, level by level.
// A response that waits under rsp_stall stays put; the next request is
// still accepted and worked on, and its response waits until the transfer.
// Reset clears the entry count and the control state; slot contents need no
// clearing since only slots that hold entries are ever used.
`timescale 1ns / 1ps
`default_nettype none

module min_heap_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	input  mhpq_pkg::req_t    req,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output mhpq_pkg::rsp_t    rsp
);
	import mhpq_pkg::*;

	// Address width for the slots and count width that can also hold CAPACITY.
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [AW-1:0] rd_addr;
	entry_t        rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	// The sequencer owns the count, the moving entry and the response register.
	mhpq_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Heap slots in array order; slot 0 is the minimum.
	mhpq_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the min-heap priority queue with remove by tag.
// A behavioral heap in this module mirrors every accepted request, so each
// response can be checked in order against what the heap should report:
// the success flag, the entry count and the current minimum entry.
module tb_top;

	import mhpq_pkg::*;

	localparam int HEAP_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1000000;
	// Cycles to keep watching after the last response, well beyond one slow
	// remove (a full tag scan plus a sift over every level).
	localparam int QUIET_CYCLES = 200;
	localparam int RANDOM_PHASE_ITEMS = 170;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Percent chance, per cycle, that the sender idles or the receiver stalls.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Mirror of the heap contents, kept in the same array order as the block.
	entry_t heap_slots[HEAP_DEPTH];
	int unsigned heap_size = 0;

	// Responses still owed by the block, oldest first.
	rsp_t expected_outcomes[$];

	int unsigned cycle_count = 0;
	int unsigned fail_count = 0;
	int unsigned n_insert = 0;
	int unsigned n_refused = 0;
	int unsigned n_remove = 0;
	int unsigned n_missing = 0;
	int unsigned peak_size = 0;

	min_heap_priority_queue #(
		.CAPACITY(HEAP_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Heap predictor
	// ------------------------------------------------------------------

	function automatic void heap_swap(int unsigned a, int unsigned b);
		entry_t held;
		held = heap_slots[a];
		heap_slots[a] = heap_slots[b];
		heap_slots[b] = held;
	endfunction

	// Climb while the parent key is strictly greater; equal keys stay put.
	function automatic void heap_sift_up(int unsigned pos);
		int unsigned up;
		while (pos > 0 && pos < heap_size) begin
			up = (pos - 1) / 2;
			if (heap_slots[up].key > heap_slots[pos].key) begin
				heap_swap(up, pos);
				pos = up;
			end else begin
				break;
			end
		end
	endfunction

	// Descend toward the smaller child; on a tie between children the left
	// one wins, and a child only moves up when it is strictly smaller.
	function automatic void heap_sift_down(int unsigned pos);
		int unsigned child;
		while (pos < heap_size) begin
			child = 2 * pos + 1;
			if (child >= heap_size)
				break;
			if (child + 1 < heap_size && heap_slots[child].key > heap_slots[child + 1].key)
				child = child + 1;
			if (heap_slots[child].key < heap_slots[pos].key) begin
				heap_swap(child, pos);
				pos = child;
			end else begin
				break;
			end
		end
	endfunction

	// Applies one request to the mirror and returns the response it must cause.
	function automatic rsp_t heap_apply(req_t r);
		rsp_t outcome;
		int unsigned pos;
		int unsigned last;
		bit ok;
		ok = 1'b0;
		if (r.func == FUNC_INSERT) begin
			n_insert++;
			if (heap_size < HEAP_DEPTH) begin
				pos = heap_size;
				heap_slots[pos].key = r.item_key;
				heap_slots[pos].tag = r.item_tag;
				heap_size++;
				heap_sift_up(pos);
				ok = 1'b1;
			end else begin
				n_refused++;
			end
		end else begin
			n_remove++;
			pos = 0;
			while (pos < heap_size && heap_slots[pos].tag != r.item_tag)
				pos++;
			if (pos < heap_size) begin
				ok = 1'b1;
				last = heap_size - 1;
				heap_size = last;
				// Taking the last slot needs no reordering at all.
				if (pos != last) begin
					heap_slots[pos] = heap_slots[last];
					if (pos != 0 && heap_slots[pos].key < heap_slots[(pos - 1) / 2].key)
						heap_sift_up(pos);
					else
						heap_sift_down(pos);
				end
			end else begin
				n_missing++;
			end
		end
		if (heap_size > peak_size)
			peak_size = heap_size;
		outcome.done_ok = ok;
		outcome.entry_count = CNT_OUT_W'(heap_size);
		outcome.top_valid = (heap_size != 0);
		outcome.top_key = (heap_size != 0) ? heap_slots[0].key : '0;
		outcome.top_tag = (heap_size != 0) ? heap_slots[0].tag : '0;
		return outcome;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// A quarter of the keys are small values, so that equal keys and ties between
	// children show up often; near-maximum and full-range keys make up the rest.
	function automatic logic [KEY_W-1:0] random_key();
		case ($urandom_range(3))
			0: return KEY_W'($urandom_range(15));
			1: return 32'hFFFF_FFF0 | KEY_W'($urandom_range(15));
			default: return KEY_W'($urandom);
		endcase
	endfunction

	// Tags mostly come from a small pool, which produces duplicates.
	function automatic logic [TAG_W-1:0] random_tag();
		if ($urandom_range(99) < 70)
			return TAG_W'($urandom_range(31));
		return TAG_W'($urandom_range(16'hFFFF));
	endfunction

	// A remove that names a tag the heap holds with the given percent chance,
	// and otherwise one that is most likely absent. The key rides along unused.
	function automatic req_t removal_request(int hit_pct);
		req_t r;
		r.func = FUNC_REMOVE;
		r.item_key = KEY_W'($urandom);
		if (heap_size != 0 && $urandom_range(99) < hit_pct)
			r.item_tag = heap_slots[$urandom_range(heap_size - 1)].tag;
		else
			r.item_tag = random_tag();
		return r;
	endfunction

	function automatic req_t insertion_request(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
		req_t r;
		r.func = FUNC_INSERT;
		r.item_key = key;
		r.item_tag = tag;
		return r;
	endfunction

	// Offers one request and returns once it has been taken. Valid is left
	// high so that the next call either idles it or replaces the payload at
	// the following falling edge, never both in the same step.
	task automatic send_request(input req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		expected_outcomes.push_back(heap_apply(r));
	endtask

	// The sender holds off until the block has answered everything.
	task automatic wait_for_all_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Response side: random stalls and the in-order checker
	// ------------------------------------------------------------------

	initial begin
		forever begin
			@(negedge clk);
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic void compare_field(string name, logic [KEY_W-1:0] want,
			logic [KEY_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_outcomes.size() == 0) begin
				$error("response transfer with no request outstanding: 0x%0h", rsp);
				fail_count++;
			end else begin
				want = expected_outcomes.pop_front();
				compare_field("done_ok", want.done_ok, rsp.done_ok);
				compare_field("entry_count", want.entry_count, rsp.entry_count);
				compare_field("top_valid", want.top_valid, rsp.top_valid);
				compare_field("top_key", want.top_key, rsp.top_key);
				compare_field("top_tag", want.top_tag, rsp.top_tag);
			end
		end
	end

	// A hung handshake must not run forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d responses outstanding.",
				cycle_count, expected_outcomes.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked sequence from an empty heap: a remove with nothing held,
	// the key and tag extremes, equal keys, a duplicate tag, a missing tag,
	// removal of the root and of the only entry, and a remove whose moved
	// entry must climb instead of sink.
	task automatic test_directed_corners();
		req_t r;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		r = removal_request(0);
		r.item_tag = 16'h0000;
		send_request(r);
		send_request(insertion_request(32'hFFFF_FFFF, 16'hFFFF));
		send_request(insertion_request(32'h0000_0000, 16'h0000));
		// Same key as the root: no swap, the first entry keeps the top.
		send_request(insertion_request(32'h0000_0000, 16'h0001));
		// The tag 1 is now held twice; the remove below takes the lower slot.
		send_request(insertion_request(32'h0000_0007, 16'h0001));
		send_request(insertion_request(32'h8000_0000, 16'h8000));
		r.item_tag = 16'h0001;
		send_request(r);
		r.item_tag = 16'h1234;
		send_request(r);
		r.item_tag = 16'h0000;
		send_request(r);
		r.item_tag = 16'h8000;
		send_request(r);
		r.item_tag = 16'hFFFF;
		send_request(r);
		r.item_tag = 16'h0001;
		send_request(r);
		send_request(insertion_request(32'h0000_0005, 16'hAAAA));
		r.item_tag = 16'hAAAA;
		send_request(r);
		// Keys 1, 10, 2, 11, 12, 3, 4 land in this array order. Removing the
		// key 11 moves the key 4 under the key 10, so it has to move up.
		send_request(insertion_request(32'd1, 16'h0101));
		send_request(insertion_request(32'd10, 16'h0102));
		send_request(insertion_request(32'd2, 16'h0103));
		send_request(insertion_request(32'd11, 16'h0104));
		send_request(insertion_request(32'd12, 16'h0105));
		send_request(insertion_request(32'd3, 16'h0106));
		send_request(insertion_request(32'd4, 16'h0107));
		r.item_tag = 16'h0104;
		send_request(r);
		wait_for_all_results();
	endtask

	// Fills the heap to capacity, offers inserts that must be refused, then
	// removes held entries in random order until the heap is empty again.
	task automatic test_fill_and_drain(int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (heap_size < HEAP_DEPTH)
			send_request(insertion_request(random_key(), random_tag()));
		send_request(insertion_request(32'h0000_0000, 16'hFFFF));
		send_request(insertion_request(KEY_W'($urandom), TAG_W'($urandom_range(16'hFFFF))));
		while (heap_size != 0)
			send_request(removal_request(100));
		send_request(removal_request(0));
		wait_for_all_results();
	endtask

	// Mixed traffic. The insert share shrinks as the heap fills, so the
	// count wanders over the whole range, now and then up to capacity.
	task automatic test_random_traffic(int idle_pct, int stall_pct);
		int insert_pct;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (RANDOM_PHASE_ITEMS) begin
			insert_pct = (heap_size < HEAP_DEPTH - 8) ? 58 : 40;
			if ($urandom_range(99) < insert_pct)
				send_request(insertion_request(random_key(), random_tag()));
			else
				send_request(removal_request(85));
		end
		wait_for_all_results();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_corners();
		test_fill_and_drain(0, 0);
		test_random_traffic(0, 0);
		test_random_traffic(52, 0);
		test_random_traffic(0, 52);
		test_random_traffic(33, 33);
		test_fill_and_drain(33, 33);

		// Everything is answered; keep watching for stray responses.
		repeat (QUIET_CYCLES) @(posedge clk);

		$display("Covered %0d inserts (%0d refused on a full heap) and %0d removes",
			n_insert, n_refused, n_remove);
		$display("(%0d with no matching tag); the heap peaked at %0d of %0d entries.",
			n_missing, peak_size, HEAP_DEPTH);
		if (fail_count == 0 && expected_outcomes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
